@@ rtl/tcdt_pkg.sv @@
// Shared types and constants for the transform constant dirty tracker.
`default_nettype none
package tcdt_pkg;

  // Item kinds
  localparam logic [2:0] KIND_INVAL     = 3'd0;
  localparam logic [2:0] KIND_IDX_A     = 3'd1;
  localparam logic [2:0] KIND_IDX_B     = 3'd2;
  localparam logic [2:0] KIND_MATERIAL  = 3'd3;
  localparam logic [2:0] KIND_VIEWPORT  = 3'd4;
  localparam logic [2:0] KIND_DIRTY_ALL = 3'd5;
  localparam logic [2:0] KIND_COLLECT   = 3'd6;

  // Span value as held internally: covers -1 up to the largest region size.
  typedef logic signed [13:0] span_t;
  localparam span_t SPAN_CLEAN = '1;

  localparam int unsigned POST_SIZE  = 256;
  localparam logic [12:0] TEX_WINDOW = 13'd12;
  localparam int unsigned NUM_RGN    = 3;   // normal, post, light
  localparam int unsigned QDEPTH     = 2;

  // Clipped range against one region
  typedef struct packed {
    logic  hit;
    span_t lo;
    span_t hi;
  } clip_t;

  // Classified item travelling from front to back
  typedef struct packed {
    logic [2:0]          kind;
    logic [12:0]         range_start;
    logic [12:0]         range_end;
    logic [31:0]         index_word;
    logic [1:0]          material_slot;
    clip_t               pos;
    clip_t [NUM_RGN-1:0] rgn;
  } op_t;

endpackage
`default_nettype wire

@@ rtl/tcdt_ifs.sv @@
// Command and result channel interfaces.
`default_nettype none
interface tcdt_cmd_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [12:0] range_start;
  logic [12:0] range_end;
  logic [31:0] index_word;
  logic [1:0]  material_slot;

  modport source(output valid, kind, range_start, range_end, index_word, material_slot,
                 input ready);
  modport sink(input valid, kind, range_start, range_end, index_word, material_slot,
               output ready);
endinterface

interface tcdt_res_if;
  logic              valid;
  logic              ready;
  logic signed [9:0] pos_lo;
  logic signed [9:0] pos_hi;
  logic signed [7:0] normal_lo;
  logic signed [7:0] normal_hi;
  logic signed [9:0] post_lo;
  logic signed [9:0] post_hi;
  logic signed [8:0] light_lo;
  logic signed [8:0] light_hi;
  logic [1:0]        tex_dirty;
  logic [3:0]        material_dirty;
  logic              viewport_dirty;
  logic              projection_dirty;

  modport source(output valid, pos_lo, pos_hi, normal_lo, normal_hi, post_lo, post_hi,
                 light_lo, light_hi, tex_dirty, material_dirty, viewport_dirty,
                 projection_dirty, input ready);
  modport sink(input valid, pos_lo, pos_hi, normal_lo, normal_hi, post_lo, post_hi,
               light_lo, light_hi, tex_dirty, material_dirty, viewport_dirty,
               projection_dirty, output ready);
endinterface
`default_nettype wire

@@ rtl/transform_constant_dirty_tracker_unit.sv @@
// Top level of the transform constant dirty tracker.
// Takes one command transaction per clock while the queue is not full. A
// collect result reaches res by this path: the front clips the range against
// all regions as it accepts, the two-entry queue registers the item on the
// accepting edge, and once the item heads the queue and the output register is
// free, the back loads the result register from the dirty state and clears
// that state. While a result waits in the output register, the back keeps
// applying non-collect items; a collect behind it holds in the queue, and cmd
// drops ready once the queue is full. Command kind 7 is taken and ignored.
`default_nettype none
module transform_constant_dirty_tracker_unit
  import tcdt_pkg::*;
#(
  parameter int unsigned POS_END     = 256,
  parameter int unsigned NORMAL_BASE = 1024,
  parameter int unsigned NORMAL_END  = 1120,
  parameter int unsigned POST_BASE   = 1280,
  parameter int unsigned LIGHT_BASE  = 1536,
  parameter int unsigned LIGHT_END   = 1664
) (
  input wire logic   clk,
  input wire logic   rst,
  tcdt_cmd_if.sink   cmd,
  tcdt_res_if.source res
);

  logic push;
  logic q_full;
  logic pop;
  logic q_valid;
  op_t  wr_op;
  op_t  rd_op;

  tcdt_front #(
    .POS_END     (POS_END),
    .NORMAL_BASE (NORMAL_BASE),
    .NORMAL_END  (NORMAL_END),
    .POST_BASE   (POST_BASE),
    .LIGHT_BASE  (LIGHT_BASE),
    .LIGHT_END   (LIGHT_END)
  ) u_front (
    .cmd    (cmd),
    .q_full (q_full),
    .push   (push),
    .op     (wr_op)
  );

  tcdt_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_op    (wr_op),
    .full     (q_full),
    .pop      (pop),
    .rd_valid (q_valid),
    .rd_op    (rd_op)
  );

  tcdt_back #(
    .POS_END     (POS_END),
    .NORMAL_BASE (NORMAL_BASE),
    .NORMAL_END  (NORMAL_END),
    .LIGHT_BASE  (LIGHT_BASE),
    .LIGHT_END   (LIGHT_END)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .op      (rd_op),
    .pop     (pop),
    .res     (res)
  );

endmodule
`default_nettype wire

@@ rtl/tcdt_front.sv @@
// Front end: accepts command transactions and clips ranges against every region.
`default_nettype none
module tcdt_front
  import tcdt_pkg::*;
#(
  parameter int unsigned POS_END     = 256,
  parameter int unsigned NORMAL_BASE = 1024,
  parameter int unsigned NORMAL_END  = 1120,
  parameter int unsigned POST_BASE   = 1280,
  parameter int unsigned LIGHT_BASE  = 1536,
  parameter int unsigned LIGHT_END   = 1664
) (
  tcdt_cmd_if.sink cmd,
  input  wire logic q_full,
  output logic      push,
  output op_t       op
);

  localparam logic signed [14:0] PEND  = 15'(POS_END);
  localparam logic signed [14:0] NBASE = 15'(NORMAL_BASE);
  localparam logic signed [14:0] NEND  = 15'(NORMAL_END);
  localparam logic signed [14:0] PBASE = 15'(POST_BASE);
  localparam logic signed [14:0] PLIM  = 15'(POST_BASE + POST_SIZE);
  localparam logic signed [14:0] LBASE = 15'(LIGHT_BASE);
  localparam logic signed [14:0] LEND  = 15'(LIGHT_END);

  function automatic clip_t clip(input logic signed [14:0] s, input logic signed [14:0] e,
                                 input logic signed [14:0] base,
                                 input logic signed [14:0] lim);
    clip_t c;
    logic signed [14:0] lo_w;
    logic signed [14:0] hi_w;
    lo_w  = (s < base) ? 15'sd0 : s - base;
    hi_w  = (e < lim) ? e - base : lim - base;
    c.hit = (s < lim) && (e > base);
    c.lo  = span_t'(lo_w);
    c.hi  = span_t'(hi_w);
    return c;
  endfunction

  logic signed [14:0] s;
  logic signed [14:0] e;

  assign s = $signed({2'b00, cmd.range_start});
  assign e = $signed({2'b00, cmd.range_end});

  assign cmd.ready = !q_full;
  // unused kind is accepted and dropped
  assign push = cmd.valid && !q_full && (cmd.kind <= KIND_COLLECT);

  always_comb begin
    op.kind          = cmd.kind;
    op.range_start   = cmd.range_start;
    op.range_end     = cmd.range_end;
    op.index_word    = cmd.index_word;
    op.material_slot = cmd.material_slot;
    // position region starts at address zero; end compared unclipped in back
    op.pos.hit       = s < PEND;
    op.pos.lo        = span_t'(s);
    op.pos.hi        = (e > PEND) ? span_t'(PEND) : span_t'(e);
    op.rgn[0]        = clip(s, e, NBASE, NEND);
    op.rgn[1]        = clip(s, e, PBASE, PLIM);
    op.rgn[2]        = clip(s, e, LBASE, LEND);
  end

endmodule
`default_nettype wire

@@ rtl/tcdt_queue.sv @@
// Short queue of classified items between front and back.
`default_nettype none
module tcdt_queue
  import tcdt_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire op_t  wr_op,
  output logic      full,
  input  wire logic pop,
  output logic      rd_valid,
  output op_t       rd_op
);

  localparam int PW = $clog2(QDEPTH);
  localparam int CW = $clog2(QDEPTH + 1);

  op_t           slots [QDEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full     = count == CW'(QDEPTH);
  assign rd_valid = count != '0;
  assign rd_op    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CW'(push) - CW'(pop);
    end
  end

endmodule
`default_nettype wire

@@ rtl/tcdt_back.sv @@
// Back end: dirty state, span merging, and the registered collect result.
`default_nettype none
module tcdt_back
  import tcdt_pkg::*;
#(
  parameter int unsigned POS_END     = 256,
  parameter int unsigned NORMAL_BASE = 1024,
  parameter int unsigned NORMAL_END  = 1120,
  parameter int unsigned LIGHT_BASE  = 1536,
  parameter int unsigned LIGHT_END   = 1664
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic q_valid,
  input  wire op_t  op,
  output logic      pop,
  tcdt_res_if.source res
);

  localparam span_t FULL_POS    = span_t'(POS_END);
  localparam span_t FULL_NORMAL = span_t'(int'(NORMAL_END) - int'(NORMAL_BASE));
  localparam span_t FULL_POST   = span_t'(POST_SIZE);
  localparam span_t FULL_LIGHT  = span_t'(int'(LIGHT_END) - int'(LIGHT_BASE));

  function automatic logic near_one(input logic [12:0] s, input logic [5:0] idx);
    logic [12:0] a;
    a = {5'b0, idx, 2'b00};
    return (s >= a) && (s < a + TEX_WINDOW);
  endfunction

  logic [31:0] index_a, index_a_next;
  logic [31:0] index_b, index_b_next;
  span_t       span_lo [4];
  span_t       span_hi [4];
  span_t       span_lo_next [4];
  span_t       span_hi_next [4];
  logic [1:0]  tex_flags, tex_flags_next;
  logic [3:0]  material_flags, material_flags_next;
  logic        viewport_flag, viewport_flag_next;
  logic        projection_flag, projection_flag_next;
  logic        res_valid;
  logic        is_collect;
  logic        near_a;
  logic        near_b;

  assign is_collect = op.kind == KIND_COLLECT;
  assign pop        = q_valid && (!is_collect || !res_valid || res.ready);
  assign res.valid  = res_valid;

  always_comb begin
    near_a = 1'b0;
    near_b = 1'b0;
    for (int k = 0; k < 4; k++) begin
      near_a = near_a | near_one(op.range_start, index_a[6 + 6*k +: 6]);
      near_b = near_b | near_one(op.range_start, index_b[6*k +: 6]);
    end
  end

  always_comb begin
    index_a_next         = index_a;
    index_b_next         = index_b;
    span_lo_next         = span_lo;
    span_hi_next         = span_hi;
    tex_flags_next       = tex_flags;
    material_flags_next  = material_flags;
    viewport_flag_next   = viewport_flag;
    projection_flag_next = projection_flag;
    if (pop) begin
      case (op.kind)
        KIND_INVAL: begin
          tex_flags_next = tex_flags | {near_b, near_a};
          if (op.pos.hit) begin
            if (span_lo[0] == SPAN_CLEAN) begin
              span_lo_next[0] = op.pos.lo;
              span_hi_next[0] = op.pos.hi;
            end else begin
              if (span_lo[0] > op.pos.lo) span_lo_next[0] = op.pos.lo;
              // grows against the unclipped end
              if ({span_hi[0][13], span_hi[0]} < $signed({2'b00, op.range_end})) begin
                span_hi_next[0] = op.pos.hi;
              end
            end
          end
          for (int r = 0; r < NUM_RGN; r++) begin
            if (op.rgn[r].hit) begin
              if (span_lo[r+1] == SPAN_CLEAN) begin
                span_lo_next[r+1] = op.rgn[r].lo;
                span_hi_next[r+1] = op.rgn[r].hi;
              end else begin
                if (span_lo[r+1] > op.rgn[r].lo) span_lo_next[r+1] = op.rgn[r].lo;
                if (span_hi[r+1] < op.rgn[r].hi) span_hi_next[r+1] = op.rgn[r].hi;
              end
            end
          end
        end
        KIND_IDX_A: begin
          if (index_a != op.index_word) begin
            tex_flags_next[0] = 1'b1;
            index_a_next      = op.index_word;
          end
        end
        KIND_IDX_B: begin
          if (index_b != op.index_word) begin
            tex_flags_next[1] = 1'b1;
            index_b_next      = op.index_word;
          end
        end
        KIND_MATERIAL: begin
          material_flags_next = material_flags | (4'b0001 << op.material_slot);
        end
        KIND_VIEWPORT: begin
          viewport_flag_next = 1'b1;
        end
        KIND_DIRTY_ALL: begin
          span_lo_next         = '{4{14'sd0}};
          span_hi_next         = '{FULL_POS, FULL_NORMAL, FULL_POST, FULL_LIGHT};
          tex_flags_next       = 2'b11;
          material_flags_next  = 4'hF;
          projection_flag_next = 1'b1;
        end
        KIND_COLLECT: begin
          span_lo_next         = '{4{SPAN_CLEAN}};
          span_hi_next         = '{4{SPAN_CLEAN}};
          tex_flags_next       = '0;
          material_flags_next  = '0;
          viewport_flag_next   = 1'b0;
          projection_flag_next = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      index_a         <= '0;
      index_b         <= '0;
      span_lo         <= '{4{14'sd0}};
      span_hi         <= '{FULL_POS, FULL_NORMAL, FULL_POST, FULL_LIGHT};
      tex_flags       <= 2'b11;
      material_flags  <= 4'hF;
      viewport_flag   <= 1'b0;
      projection_flag <= 1'b1;
    end else begin
      index_a         <= index_a_next;
      index_b         <= index_b_next;
      span_lo         <= span_lo_next;
      span_hi         <= span_hi_next;
      tex_flags       <= tex_flags_next;
      material_flags  <= material_flags_next;
      viewport_flag   <= viewport_flag_next;
      projection_flag <= projection_flag_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (pop && is_collect) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && is_collect) begin
      res.pos_lo           <= span_lo[0][9:0];
      res.pos_hi           <= span_hi[0][9:0];
      res.normal_lo        <= span_lo[1][7:0];
      res.normal_hi        <= span_hi[1][7:0];
      res.post_lo          <= span_lo[2][9:0];
      res.post_hi          <= span_hi[2][9:0];
      res.light_lo         <= span_lo[3][8:0];
      res.light_hi         <= span_hi[3][8:0];
      res.tex_dirty        <= tex_flags;
      res.material_dirty   <= material_flags;
      res.viewport_dirty   <= viewport_flag;
      res.projection_dirty <= projection_flag;
    end
  end

endmodule
`default_nettype wire

@@ rtl/tcdt_checker.sv @@
// Port-level checker for the dirty tracker, bound to the top level.
`default_nettype none
module tcdt_checker
  import tcdt_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              cmd_valid,
  input wire logic              cmd_ready,
  input wire logic [2:0]        cmd_kind,
  input wire logic              res_valid,
  input wire logic              res_ready,
  input wire logic signed [9:0] res_pos_lo,
  input wire logic signed [9:0] res_pos_hi,
  input wire logic signed [8:0] res_light_lo,
  input wire logic signed [8:0] res_light_hi,
  input wire logic [3:0]        res_material
);

  logic [3:0] pending;
  logic       collect_in;
  logic       res_out;

  assign collect_in = cmd_valid && cmd_ready && (cmd_kind == KIND_COLLECT);
  assign res_out    = res_valid && res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + 4'(collect_in) - 4'(res_out);
    end
  end

  // no result without an outstanding collect transaction
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> pending != '0)
    else $error("result without outstanding collect");

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_pos_lo) && $stable(res_pos_hi)
      && $stable(res_material))
    else $error("stalled result changed");

  // the position and light spans are each clean at both ends or at neither
  a_span_pair: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> ((res_pos_lo == -10'sd1) == (res_pos_hi == -10'sd1))
      && ((res_light_lo == -9'sd1) == (res_light_hi == -9'sd1)))
    else $error("half-clean span");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid after reset");

endmodule

bind transform_constant_dirty_tracker_unit tcdt_checker u_tcdt_checker (
  .clk          (clk),
  .rst          (rst),
  .cmd_valid    (cmd.valid),
  .cmd_ready    (cmd.ready),
  .cmd_kind     (cmd.kind),
  .res_valid    (res.valid),
  .res_ready    (res.ready),
  .res_pos_lo   (res.pos_lo),
  .res_pos_hi   (res.pos_hi),
  .res_light_lo (res.light_lo),
  .res_light_hi (res.light_hi),
  .res_material (res.material_dirty)
);
`default_nettype wire

@@ bench/tb_transform_constant_dirty_tracker_unit.sv @@
// Testbench for transform_constant_dirty_tracker_unit: random command stream checked against a predictor.
module tb_transform_constant_dirty_tracker_unit;
  import tcdt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int POS_END     = 256;
  localparam int NORMAL_BASE = 1024;
  localparam int NORMAL_END  = 1120;
  localparam int POST_BASE   = 1280;
  localparam int LIGHT_BASE  = 1536;
  localparam int LIGHT_END   = 1664;
  localparam int POST_END    = POST_BASE + POST_SIZE;
  localparam int NUM_ITEMS   = 1450;
  localparam int IDLE_LIMIT  = 2000;
  localparam int TAIL_CYCLES = 8;
  localparam logic [2:0] KIND_UNUSED = 3'd7;

  typedef struct packed {
    logic [2:0]  kind;
    logic [12:0] range_start;
    logic [12:0] range_end;
    logic [31:0] index_word;
    logic [1:0]  material_slot;
  } tracker_cmd_t;

  typedef struct packed {
    logic [9:0] pos_lo;
    logic [9:0] pos_hi;
    logic [7:0] normal_lo;
    logic [7:0] normal_hi;
    logic [9:0] post_lo;
    logic [9:0] post_hi;
    logic [8:0] light_lo;
    logic [8:0] light_hi;
    logic [1:0] tex;
    logic [3:0] material;
    logic       viewport;
    logic       projection;
  } dirty_report_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  tcdt_cmd_if cmd_bus();
  tcdt_res_if res_bus();

  transform_constant_dirty_tracker_unit #(
    .POS_END(POS_END), .NORMAL_BASE(NORMAL_BASE), .NORMAL_END(NORMAL_END),
    .POST_BASE(POST_BASE), .LIGHT_BASE(LIGHT_BASE), .LIGHT_END(LIGHT_END)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cmd(cmd_bus),
    .res(res_bus)
  );

  always #10 clk = ~clk;

  // Tracked dirty state
  logic [31:0]   trk_index_a, trk_index_b;
  int            trk_lo[4], trk_hi[4];
  logic [1:0]    trk_tex;
  logic [3:0]    trk_material;
  logic          trk_viewport, trk_projection;

  tracker_cmd_t  cmd_backlog[$];
  dirty_report_t expected_reports[$];
  dirty_report_t want_rpt, snap_rpt;
  tracker_cmd_t  next_cmd;

  int  mismatches = 0;
  int  n_accepted = 0, n_inval = 0, n_index = 0, n_checked = 0;
  bit  cmd_fired = 1'b0;
  int  si, ei, pos_clip;
  int  burst_left = 0, gap_left = 0;
  int  sink_mode = 0, sink_phase = 0, sink_span = 50;
  logic [31:0] gen_idx_a = '0, gen_idx_b = '0;

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatches++;
    if (mismatches <= 40)
      $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
  endtask

  task automatic mark_all_dirty();
    trk_lo[0] = 0; trk_hi[0] = POS_END;
    trk_lo[1] = 0; trk_hi[1] = NORMAL_END - NORMAL_BASE;
    trk_lo[2] = 0; trk_hi[2] = POST_SIZE;
    trk_lo[3] = 0; trk_hi[3] = LIGHT_END - LIGHT_BASE;
    trk_tex = 2'b11;
    trk_material = 4'hF;
    trk_projection = 1'b1;
  endtask

  function automatic bit window_hit(int s, logic [31:0] word, int shift);
    int a;
    for (int k = 0; k < 4; k++) begin
      a = int'((word >> (shift + 6 * k)) & 32'h3F) * 4;
      if (s >= a && s < a + 12) return 1'b1;
    end
    return 1'b0;
  endfunction

  // Clip one range against a region and fold it into the region's span
  task automatic clip_merge(int r, int s, int e, int base, int lim);
    int lo, hi;
    if (s < lim && e > base) begin
      lo = (s < base) ? 0 : s - base;
      hi = (e < lim) ? e - base : lim - base;
      if (trk_lo[r] == -1) begin
        trk_lo[r] = lo;
        trk_hi[r] = hi;
      end else begin
        if (trk_lo[r] > lo) trk_lo[r] = lo;
        if (trk_hi[r] < hi) trk_hi[r] = hi;
      end
    end
  endtask

  task automatic push_cmd(logic [2:0] kind, int rs, int re, logic [31:0] word, logic [1:0] slot);
    tracker_cmd_t c;
    c.kind = kind;
    c.range_start = rs[12:0];
    c.range_end = re[12:0];
    c.index_word = word;
    c.material_slot = slot;
    if (kind == KIND_IDX_A) gen_idx_a = word;
    if (kind == KIND_IDX_B) gen_idx_b = word;
    cmd_backlog.push_back(c);
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) report_mismatch(name, got, want);
  endtask

  // Monitor and predictor
  always @(posedge clk) begin
    cmd_fired = !rst && cmd_bus.valid && cmd_bus.ready;
    if (!rst && res_bus.valid && res_bus.ready) begin
      if (expected_reports.size() == 0) begin
        report_mismatch("result with nothing expected", 32'd1, 32'd0);
      end else begin
        want_rpt = expected_reports.pop_front();
        check_field("pos_lo", $unsigned(res_bus.pos_lo), want_rpt.pos_lo);
        check_field("pos_hi", $unsigned(res_bus.pos_hi), want_rpt.pos_hi);
        check_field("normal_lo", $unsigned(res_bus.normal_lo), want_rpt.normal_lo);
        check_field("normal_hi", $unsigned(res_bus.normal_hi), want_rpt.normal_hi);
        check_field("post_lo", $unsigned(res_bus.post_lo), want_rpt.post_lo);
        check_field("post_hi", $unsigned(res_bus.post_hi), want_rpt.post_hi);
        check_field("light_lo", $unsigned(res_bus.light_lo), want_rpt.light_lo);
        check_field("light_hi", $unsigned(res_bus.light_hi), want_rpt.light_hi);
        check_field("tex_dirty", res_bus.tex_dirty, want_rpt.tex);
        check_field("material_dirty", res_bus.material_dirty, want_rpt.material);
        check_field("viewport_dirty", res_bus.viewport_dirty, want_rpt.viewport);
        check_field("projection_dirty", res_bus.projection_dirty, want_rpt.projection);
        n_checked++;
      end
    end
    if (cmd_fired) begin
      n_accepted++;
      case (cmd_bus.kind)
        KIND_INVAL: begin
          n_inval++;
          si = int'(cmd_bus.range_start);
          ei = int'(cmd_bus.range_end);
          if (window_hit(si, trk_index_a, 6)) trk_tex[0] = 1'b1;
          if (window_hit(si, trk_index_b, 0)) trk_tex[1] = 1'b1;
          // position region: only the start decides, end compared unclipped
          if (si < POS_END) begin
            pos_clip = (ei > POS_END) ? POS_END : ei;
            if (trk_lo[0] == -1) begin
              trk_lo[0] = si;
              trk_hi[0] = pos_clip;
            end else begin
              if (trk_lo[0] > si) trk_lo[0] = si;
              if (trk_hi[0] < ei) trk_hi[0] = pos_clip;
            end
          end
          clip_merge(1, si, ei, NORMAL_BASE, NORMAL_END);
          clip_merge(2, si, ei, POST_BASE, POST_END);
          clip_merge(3, si, ei, LIGHT_BASE, LIGHT_END);
        end
        KIND_IDX_A: begin
          n_index++;
          if (trk_index_a != cmd_bus.index_word) begin
            trk_tex[0] = 1'b1;
            trk_index_a = cmd_bus.index_word;
          end
        end
        KIND_IDX_B: begin
          n_index++;
          if (trk_index_b != cmd_bus.index_word) begin
            trk_tex[1] = 1'b1;
            trk_index_b = cmd_bus.index_word;
          end
        end
        KIND_MATERIAL: trk_material[cmd_bus.material_slot] = 1'b1;
        KIND_VIEWPORT: trk_viewport = 1'b1;
        KIND_DIRTY_ALL: mark_all_dirty();
        KIND_COLLECT: begin
          snap_rpt.pos_lo = trk_lo[0][9:0];
          snap_rpt.pos_hi = trk_hi[0][9:0];
          snap_rpt.normal_lo = trk_lo[1][7:0];
          snap_rpt.normal_hi = trk_hi[1][7:0];
          snap_rpt.post_lo = trk_lo[2][9:0];
          snap_rpt.post_hi = trk_hi[2][9:0];
          snap_rpt.light_lo = trk_lo[3][8:0];
          snap_rpt.light_hi = trk_hi[3][8:0];
          snap_rpt.tex = trk_tex;
          snap_rpt.material = trk_material;
          snap_rpt.viewport = trk_viewport;
          snap_rpt.projection = trk_projection;
          expected_reports.push_back(snap_rpt);
          for (int r = 0; r < 4; r++) begin
            trk_lo[r] = -1;
            trk_hi[r] = -1;
          end
          trk_tex = '0;
          trk_material = '0;
          trk_viewport = 1'b0;
          trk_projection = 1'b0;
        end
        default: ;
      endcase
    end
  end

  // Command driver: bursts with random gaps, some long gapless stretches
  always @(negedge clk) begin
    if (!rst && (!cmd_bus.valid || cmd_fired)) begin
      if (gap_left > 0) begin
        gap_left--;
        cmd_bus.valid <= 1'b0;
      end else if (cmd_backlog.size() == 0) begin
        cmd_bus.valid <= 1'b0;
      end else begin
        next_cmd = cmd_backlog.pop_front();
        cmd_bus.kind <= next_cmd.kind;
        cmd_bus.range_start <= next_cmd.range_start;
        cmd_bus.range_end <= next_cmd.range_end;
        cmd_bus.index_word <= next_cmd.index_word;
        cmd_bus.material_slot <= next_cmd.material_slot;
        cmd_bus.valid <= 1'b1;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          if ($urandom_range(0, 7) == 0) begin
            burst_left = 80;
            gap_left = 0;
          end else begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end
    end
  end

  // Result sink: stall pattern switches between modes every so often
  always @(negedge clk) begin
    if (!rst) begin
      case (sink_mode)
        0:       res_bus.ready <= 1'b1;
        1:       res_bus.ready <= 1'($urandom_range(0, 1));
        2:       res_bus.ready <= (sink_phase % 7) < 4;
        default: res_bus.ready <= (sink_phase % 9) == 0;
      endcase
      sink_phase++;
      if (sink_phase >= sink_span) begin
        sink_phase = 0;
        sink_span = $urandom_range(30, 150);
        sink_mode = $urandom_range(0, 3);
      end
    end
  end

  // Watchdog on transactions
  int idle_cycles = 0;
  always @(posedge clk) begin
    if (rst || (cmd_bus.valid && cmd_bus.ready) || (res_bus.valid && res_bus.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
      $display("tb_transform_constant_dirty_tracker_unit NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int bounds[8];
    int produced, pick, s, e, a, field;
    logic [31:0] w;

    cmd_bus.valid = 1'b0;
    cmd_bus.kind = KIND_INVAL;
    cmd_bus.range_start = '0;
    cmd_bus.range_end = '0;
    cmd_bus.index_word = '0;
    cmd_bus.material_slot = '0;
    res_bus.ready = 1'b0;

    trk_index_a = '0;
    trk_index_b = '0;
    trk_viewport = 1'b0;
    mark_all_dirty();

    bounds = '{0, POS_END, NORMAL_BASE, NORMAL_END, POST_BASE, POST_END, LIGHT_BASE, LIGHT_END};

    // Directed opening
    push_cmd(KIND_COLLECT, 0, 0, '0, 2'd0);       // state after reset
    push_cmd(KIND_COLLECT, 0, 0, '0, 2'd0);       // everything clean
    push_cmd(KIND_INVAL, 0, POS_END, '0, 2'd0);   // starts inside index-0 window
    push_cmd(KIND_INVAL, 1000, 1700, '0, 2'd0);   // below bases, past ends
    push_cmd(KIND_INVAL, 250, 300, '0, 2'd0);     // position end clipped
    push_cmd(KIND_COLLECT, 0, 0, '0, 2'd0);
    push_cmd(KIND_INVAL, 8191, 0, '0, 2'd0);      // end below start, top address
    push_cmd(KIND_INVAL, 100, 50, '0, 2'd0);
    push_cmd(KIND_INVAL, 1100, 1050, '0, 2'd0);
    push_cmd(KIND_IDX_A, 0, 0, 32'h0, 2'd0);      // unchanged words
    push_cmd(KIND_IDX_B, 0, 0, 32'h0, 2'd0);
    push_cmd(KIND_COLLECT, 0, 0, '0, 2'd0);
    push_cmd(KIND_IDX_A, 0, 0, 32'hFFFF_FFFF, 2'd0);
    push_cmd(KIND_IDX_B, 0, 0, 32'hFFFF_FFFF, 2'd0);
    for (int k = 0; k < 4; k++) push_cmd(KIND_MATERIAL, 0, 0, '0, 2'(k));
    push_cmd(KIND_VIEWPORT, 0, 0, '0, 2'd0);
    push_cmd(KIND_COLLECT, 0, 0, '0, 2'd0);
    push_cmd(KIND_INVAL, 252, 4096, '0, 2'd0);    // window of index 63
    push_cmd(KIND_VIEWPORT, 0, 0, '0, 2'd0);
    push_cmd(KIND_DIRTY_ALL, 0, 0, '0, 2'd0);     // viewport must survive
    push_cmd(KIND_UNUSED, 8191, 8191, 32'hFFFF_FFFF, 2'd3);
    push_cmd(KIND_COLLECT, 0, 0, '0, 2'd0);

    // Random part
    produced = cmd_backlog.size() - 1;
    while (produced < NUM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 48) begin
        case ($urandom_range(0, 5))
          0: begin
            s = $urandom_range(0, 300);
            e = s + $urandom_range(0, 40);
          end
          1, 2: begin
            s = bounds[$urandom_range(0, 7)] - 24 + $urandom_range(0, 48);
            if (s < 0) s = 0;
            e = s + $urandom_range(0, 300);
          end
          3: begin
            w = $urandom_range(0, 1) ? gen_idx_a : gen_idx_b;
            field = $urandom_range(0, 4);
            a = int'((w >> (6 * field)) & 32'h3F) * 4;
            s = a - 1 + $urandom_range(0, 14);
            if (s < 0) s = 0;
            e = s + $urandom_range(0, 64);
          end
          4: begin
            s = $urandom_range(0, 8191);
            e = $urandom_range(0, 8191);
          end
          default: begin
            s = $urandom_range(1, 1800);
            e = s - $urandom_range(1, s);
          end
        endcase
        if (e > 8191) e = 8191;
        push_cmd(KIND_INVAL, s, e, '0, 2'($urandom_range(0, 3)));
        produced++;
      end else if (pick < 58) begin
        case ($urandom_range(0, 3))
          0, 1: w = $urandom();
          2:    w = (pick < 53) ? gen_idx_a : gen_idx_b;
          default: w = $urandom() & 32'h0F3C_F3CF;
        endcase
        push_cmd((pick < 53) ? KIND_IDX_A : KIND_IDX_B, $urandom_range(0, 8191),
                 $urandom_range(0, 8191), w, 2'($urandom_range(0, 3)));
        produced++;
      end else if (pick < 66) begin
        push_cmd(KIND_MATERIAL, 0, 0, $urandom(), 2'($urandom_range(0, 3)));
        produced++;
      end else if (pick < 71) begin
        push_cmd(KIND_VIEWPORT, 0, 0, '0, 2'd0);
        produced++;
      end else if (pick < 74) begin
        push_cmd(KIND_DIRTY_ALL, 0, 0, '0, 2'd0);
        produced++;
      end else if (pick < 97) begin
        push_cmd(KIND_COLLECT, $urandom_range(0, 8191), 0, $urandom(), 2'd0);
        produced++;
      end else begin
        push_cmd(KIND_UNUSED, $urandom_range(0, 8191), $urandom_range(0, 8191),
                 $urandom(), 2'($urandom_range(0, 3)));
      end
    end
    push_cmd(KIND_COLLECT, 0, 0, '0, 2'd0);

    repeat (8) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    while (cmd_backlog.size() != 0 || cmd_bus.valid || expected_reports.size() != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (expected_reports.size() != 0)
      report_mismatch("results never produced", 32'd0, expected_reports.size());
    $display("ran %0d commands: %0d range writes, %0d index writes, %0d collect results checked",
             n_accepted, n_inval, n_index, n_checked);
    $display("%0d mismatches", mismatches);
    if (mismatches == 0) begin
      $display("tb_transform_constant_dirty_tracker_unit OK");
    end else begin
      $display("tb_transform_constant_dirty_tracker_unit NOT OK");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/tcdt_pkg.sv
rtl/tcdt_ifs.sv
rtl/tcdt_front.sv
rtl/tcdt_queue.sv
rtl/tcdt_back.sv
rtl/transform_constant_dirty_tracker_unit.sv
rtl/tcdt_checker.sv
bench/tb_transform_constant_dirty_tracker_unit.sv
